@@ src/dhb_pkg.sv @@
// Package: shared constants and state types for the dominant hue bin colour block.
package dhb_pkg;

   localparam int HUE_BINS_DEF   = 18;
   localparam int MAX_PIXELS_DEF = 65536;

   localparam int CHAN_W  = 8;    // colour channel, saturation, value
   localparam int HUE_W   = 9;    // hue in degrees
   localparam int BIN_W   = 5;    // winning bin field
   localparam int HUE_MAX = 359;
   localparam int HUE_CIRCLE = 360;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_DIV
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_ACC,
      BACK_SCAN,
      BACK_LOAD,
      BACK_WAIT
   } back_state_type;

endpackage

@@ src/dhb_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module dhb_divider #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 8,
   parameter int QUO_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [QUO_W-1:0] quotient
);

   localparam int CntW = $clog2(QUO_W);

   logic             busy_ff, busy_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   // numer must be below denom * 2**QUO_W, so the top part fits the remainder
   // denom is captured at start; the source may move on while the steps run
   always_comb begin
      trial   = {rem_ff, low_ff[QUO_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_W'(numer >> QUO_W);
         den_in  = denom;
         low_in  = numer[QUO_W-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in = {low_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(QUO_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
   end

   assign busy     = busy_ff;
   assign quotient = low_ff;

endmodule

@@ src/dhb_front.sv @@
// Front end: takes a pixel, converts it to HSV and picks its hue bin.
module dhb_front #(
   parameter int HUE_BINS = dhb_pkg::HUE_BINS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [dhb_pkg::CHAN_W-1:0]       req_red,
   input  logic [dhb_pkg::CHAN_W-1:0]       req_green,
   input  logic [dhb_pkg::CHAN_W-1:0]       req_blue,
   input  logic                             req_last_pixel,
   input  logic                             q_full,
   output logic                             q_push,
   output logic [$clog2(HUE_BINS)-1:0]      pix_idx,
   output logic [dhb_pkg::HUE_W-1:0]        pix_hue,
   output logic [dhb_pkg::CHAN_W-1:0]       pix_sat,
   output logic [dhb_pkg::CHAN_W-1:0]       pix_val,
   output logic                             pix_last
);

   localparam int IdxW   = $clog2(HUE_BINS);
   localparam int BinDeg = dhb_pkg::HUE_CIRCLE / HUE_BINS;
   localparam int NumW   = 17;
   // hue / BinDeg as a reciprocal multiply, exact for any hue below 512
   localparam int RecipSh  = 18;
   localparam int RecipMul = ((1 << RecipSh) + BinDeg - 1) / BinDeg;
   localparam int ProdW    = dhb_pkg::HUE_W + RecipSh;

   dhb_pkg::front_state_type state_ff, state_in;

   logic [dhb_pkg::CHAN_W-1:0] mx, mn, delta;
   logic [NumW-1:0]            d17, hue_num, sat_num;
   logic [dhb_pkg::CHAN_W-1:0] mx_ff, delta_ff;
   logic                       last_ff;
   logic                       accept, start;
   logic                       hue_busy, sat_busy;
   logic [dhb_pkg::HUE_W-1:0]  hue_q, sat_q, hue, idx_raw;
   logic [ProdW-1:0]           idx_prod;

   assign accept = req_push && !req_full;

   // channel extremes and the sector numerators
   always_comb begin
      mx = req_red;
      mn = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx)  mx = req_blue;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn)  mn = req_blue;
      delta   = mx - mn;
      d17     = NumW'(delta);
      sat_num = NumW'(510) * d17 + NumW'(mx);
      if (mx == req_red) begin
         if (req_green >= req_blue)
            hue_num = NumW'(60) * NumW'(req_green - req_blue);
         else
            hue_num = NumW'(360) * d17 - NumW'(60) * NumW'(req_blue - req_green);
      end else if (mx == req_green) begin
         if (req_blue >= req_red)
            hue_num = NumW'(120) * d17 + NumW'(60) * NumW'(req_blue - req_red);
         else
            hue_num = NumW'(120) * d17 - NumW'(60) * NumW'(req_red - req_blue);
      end else begin
         if (req_red >= req_green)
            hue_num = NumW'(240) * d17 + NumW'(60) * NumW'(req_red - req_green);
         else
            hue_num = NumW'(240) * d17 - NumW'(60) * NumW'(req_green - req_red);
      end
   end

   dhb_divider #(.NUM_W(NumW), .DEN_W(dhb_pkg::CHAN_W), .QUO_W(dhb_pkg::HUE_W)) u_hue_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .numer    (hue_num),
      .denom    (delta),
      .busy     (hue_busy),
      .quotient (hue_q)
   );

   dhb_divider #(.NUM_W(NumW), .DEN_W(dhb_pkg::CHAN_W + 1), .QUO_W(dhb_pkg::HUE_W)) u_sat_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .numer    (sat_num),
      .denom    ({mx, 1'b0}),
      .busy     (sat_busy),
      .quotient (sat_q)
   );

   // finished pixel fields
   always_comb begin
      if (delta_ff == '0)
         hue = '0;
      else if (hue_q > dhb_pkg::HUE_W'(dhb_pkg::HUE_MAX))
         hue = dhb_pkg::HUE_W'(dhb_pkg::HUE_MAX);
      else
         hue = hue_q;
      idx_prod = ProdW'(hue) * ProdW'(RecipMul);
      idx_raw  = dhb_pkg::HUE_W'(idx_prod >> RecipSh);
      if (idx_raw > dhb_pkg::HUE_W'(HUE_BINS - 1))
         pix_idx = IdxW'(HUE_BINS - 1);
      else
         pix_idx = IdxW'(idx_raw);
      pix_hue  = hue;
      pix_sat  = (mx_ff == '0) ? '0 : sat_q[dhb_pkg::CHAN_W-1:0];
      pix_val  = mx_ff;
      pix_last = last_ff;
   end

   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      q_push   = 1'b0;
      req_full = 1'b1;
      unique case (state_ff)
         dhb_pkg::FRONT_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               start    = 1'b1;
               state_in = dhb_pkg::FRONT_DIV;
            end
         end
         dhb_pkg::FRONT_DIV: begin
            if (!hue_busy && !sat_busy && !q_full) begin
               q_push   = 1'b1;
               state_in = dhb_pkg::FRONT_IDLE;
            end
         end
         default: state_in = dhb_pkg::FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhb_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         mx_ff    <= mx;
         delta_ff <= delta;
         last_ff  <= req_last_pixel;
      end
   end

endmodule

@@ src/dhb_queue.sv @@
// Two-entry queue between front and back ends.
module dhb_queue #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem[wr_ff] <= push_data;
   end

endmodule

@@ src/dhb_back.sv @@
// Back end: bin accumulation, winner scan, averaging and the result register.
module dhb_back #(
   parameter int HUE_BINS   = dhb_pkg::HUE_BINS_DEF,
   parameter int MAX_PIXELS = dhb_pkg::MAX_PIXELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   output logic                         q_pop,
   input  logic [$clog2(HUE_BINS)-1:0]  pix_idx,
   input  logic [dhb_pkg::HUE_W-1:0]    pix_hue,
   input  logic [dhb_pkg::CHAN_W-1:0]   pix_sat,
   input  logic [dhb_pkg::CHAN_W-1:0]   pix_val,
   input  logic                         pix_last,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [dhb_pkg::HUE_W-1:0]    rsp_avg_hue,
   output logic [dhb_pkg::CHAN_W-1:0]   rsp_avg_saturation,
   output logic [dhb_pkg::CHAN_W-1:0]   rsp_avg_value,
   output logic [dhb_pkg::BIN_W-1:0]    rsp_winning_bin
);

   localparam int IdxW    = $clog2(HUE_BINS);
   localparam int CountW  = $clog2(MAX_PIXELS + 1);
   localparam int HueSumW = $clog2(64'(MAX_PIXELS) * 64'(dhb_pkg::HUE_MAX) + 64'd1);
   localparam int SatSumW = $clog2(64'(MAX_PIXELS) * 64'd255 + 64'd1);
   localparam int ScoreW  = ((HueSumW > SatSumW + 1) ? HueSumW : SatSumW + 1) + 1;

   dhb_pkg::back_state_type state_ff, state_in;

   logic [CountW-1:0]  cnt_ff [HUE_BINS];
   logic [HueSumW-1:0] hsum_ff [HUE_BINS];
   logic [SatSumW-1:0] ssum_ff [HUE_BINS];
   logic [SatSumW-1:0] vsum_ff [HUE_BINS];
   logic [HUE_BINS-1:0] valid_ff;

   logic [IdxW-1:0]    addr, scan_ff, scan_in, best_ff, best_in;
   logic [ScoreW-1:0]  best_score_ff, best_score_in, score;
   logic [CountW-1:0]  rd_cnt;
   logic [HueSumW-1:0] rd_hsum;
   logic [SatSumW-1:0] rd_ssum, rd_vsum;
   logic               rd_valid, acc_wr, clear_bins, start, out_load, out_free;
   logic               zero_ff, out_valid_ff;
   logic               hue_busy, sat_busy, val_busy;
   logic [dhb_pkg::HUE_W-1:0]  hue_q;
   logic [dhb_pkg::CHAN_W-1:0] sat_q, val_q;

   // one read address, chosen by what the back end is doing
   always_comb begin
      unique case (state_ff)
         dhb_pkg::BACK_SCAN: addr = scan_ff;
         dhb_pkg::BACK_LOAD: addr = best_ff;
         default:            addr = pix_idx;
      endcase
      rd_valid = valid_ff[addr];
      rd_cnt   = rd_valid ? cnt_ff[addr]  : '0;
      rd_hsum  = rd_valid ? hsum_ff[addr] : '0;
      rd_ssum  = rd_valid ? ssum_ff[addr] : '0;
      rd_vsum  = rd_valid ? vsum_ff[addr] : '0;
      score    = ScoreW'(rd_hsum) + (ScoreW'(rd_ssum) << 1);
   end

   assign out_free = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_score_in = best_score_ff;
      q_pop         = 1'b0;
      acc_wr        = 1'b0;
      start         = 1'b0;
      out_load      = 1'b0;
      clear_bins    = 1'b0;
      unique case (state_ff)
         dhb_pkg::BACK_ACC: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               acc_wr = rd_cnt < CountW'(MAX_PIXELS);
               if (pix_last) begin
                  scan_in  = '0;
                  state_in = dhb_pkg::BACK_SCAN;
               end
            end
         end
         dhb_pkg::BACK_SCAN: begin
            if (scan_ff == '0 || score > best_score_ff) begin
               best_in       = scan_ff;
               best_score_in = score;
            end
            if (scan_ff == IdxW'(HUE_BINS - 1))
               state_in = dhb_pkg::BACK_LOAD;
            else
               scan_in = scan_ff + IdxW'(1);
         end
         dhb_pkg::BACK_LOAD: begin
            start    = 1'b1;
            state_in = dhb_pkg::BACK_WAIT;
         end
         dhb_pkg::BACK_WAIT: begin
            if (!hue_busy && !sat_busy && !val_busy && out_free) begin
               out_load   = 1'b1;
               clear_bins = 1'b1;
               state_in   = dhb_pkg::BACK_ACC;
            end
         end
         default: state_in = dhb_pkg::BACK_ACC;
      endcase
   end

   dhb_divider #(.NUM_W(HueSumW), .DEN_W(CountW), .QUO_W(dhb_pkg::HUE_W)) u_hue_avg (
      .clock (clock), .reset (reset), .start (start), .numer (rd_hsum),
      .denom (rd_cnt), .busy (hue_busy), .quotient (hue_q)
   );

   dhb_divider #(.NUM_W(SatSumW), .DEN_W(CountW), .QUO_W(dhb_pkg::CHAN_W)) u_sat_avg (
      .clock (clock), .reset (reset), .start (start), .numer (rd_ssum),
      .denom (rd_cnt), .busy (sat_busy), .quotient (sat_q)
   );

   dhb_divider #(.NUM_W(SatSumW), .DEN_W(CountW), .QUO_W(dhb_pkg::CHAN_W)) u_val_avg (
      .clock (clock), .reset (reset), .start (start), .numer (rd_vsum),
      .denom (rd_cnt), .busy (val_busy), .quotient (val_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhb_pkg::BACK_ACC;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clear_bins)
            valid_ff <= '0;
         else if (acc_wr)
            valid_ff[addr] <= 1'b1;
         if (out_load)
            out_valid_ff <= 1'b1;
         else if (rsp_pop)
            out_valid_ff <= 1'b0;
      end
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_score_ff <= best_score_in;
      if (start) zero_ff <= rd_cnt == '0;
      if (acc_wr) begin
         cnt_ff[addr]  <= rd_cnt + CountW'(1);
         hsum_ff[addr] <= rd_hsum + HueSumW'(pix_hue);
         ssum_ff[addr] <= rd_ssum + SatSumW'(pix_sat);
         vsum_ff[addr] <= rd_vsum + SatSumW'(pix_val);
      end
      if (out_load) begin
         rsp_avg_hue        <= zero_ff ? '0 : hue_q;
         rsp_avg_saturation <= zero_ff ? '0 : sat_q;
         rsp_avg_value      <= zero_ff ? '0 : val_q;
         rsp_winning_bin    <= dhb_pkg::BIN_W'(best_ff);
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule

@@ src/dominant_hue_bin_color.sv @@
// Top level of the dominant hue bin colour block.
//
// Pixels (8-bit RGB) are pushed in as requests; each is converted to HSV and added
// to one of HUE_BINS hue bins of 360/HUE_BINS degrees. A request with last_pixel set
// closes the image: the bin with the largest hue sum plus twice its saturation sum
// wins (lowest index on a tie), its truncated averages come out as one result, and
// all bins start again from zero. The front end takes a pixel, runs nine steps of the
// two one-bit-per-cycle dividers for hue and saturation, hands it to the queue when
// there is room, and only then takes the next. The back end takes one pixel per cycle
// from the two-entry queue when accumulating and the queue is not empty. After the
// last pixel it scans the bins, loads the winner, runs the averaging dividers and
// writes the result once the previous one is popped, while the front end converts
// pixels until the queue fills. A full bin (MAX_PIXELS pixels) ignores further pixels.
module dominant_hue_bin_color #(
   parameter int HUE_BINS   = dhb_pkg::HUE_BINS_DEF,
   parameter int MAX_PIXELS = dhb_pkg::MAX_PIXELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [dhb_pkg::CHAN_W-1:0] req_red,
   input  logic [dhb_pkg::CHAN_W-1:0] req_green,
   input  logic [dhb_pkg::CHAN_W-1:0] req_blue,
   input  logic                       req_last_pixel,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [dhb_pkg::HUE_W-1:0]  rsp_avg_hue,
   output logic [dhb_pkg::CHAN_W-1:0] rsp_avg_saturation,
   output logic [dhb_pkg::CHAN_W-1:0] rsp_avg_value,
   output logic [dhb_pkg::BIN_W-1:0]  rsp_winning_bin
);

   localparam int IdxW = $clog2(HUE_BINS);
   // queue word: bin index, hue, saturation, value, last flag
   localparam int PixW = IdxW + dhb_pkg::HUE_W + 2 * dhb_pkg::CHAN_W + 1;

   logic                       q_push, q_pop, q_full, q_empty;
   logic [PixW-1:0]            q_wdata, q_rdata;
   logic [IdxW-1:0]            f_idx, b_idx;
   logic [dhb_pkg::HUE_W-1:0]  f_hue, b_hue;
   logic [dhb_pkg::CHAN_W-1:0] f_sat, f_val, b_sat, b_val;
   logic                       f_last, b_last;

   dhb_front #(.HUE_BINS(HUE_BINS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .q_full         (q_full),
      .q_push         (q_push),
      .pix_idx        (f_idx),
      .pix_hue        (f_hue),
      .pix_sat        (f_sat),
      .pix_val        (f_val),
      .pix_last       (f_last)
   );

   assign q_wdata = {f_idx, f_hue, f_sat, f_val, f_last};

   dhb_queue #(.WIDTH(PixW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   assign {b_idx, b_hue, b_sat, b_val, b_last} = q_rdata;

   dhb_back #(.HUE_BINS(HUE_BINS), .MAX_PIXELS(MAX_PIXELS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .pix_idx            (b_idx),
      .pix_hue            (b_hue),
      .pix_sat            (b_sat),
      .pix_val            (b_val),
      .pix_last           (b_last),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_avg_hue        (rsp_avg_hue),
      .rsp_avg_saturation (rsp_avg_saturation),
      .rsp_avg_value      (rsp_avg_value),
      .rsp_winning_bin    (rsp_winning_bin)
   );

   // front end never overruns the queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset) q_full |-> !q_push)
      else $error("push into full queue");

   // back end never takes from an empty queue
   a_no_underrun: assert property (@(posedge clock) disable iff (reset) q_empty |-> !q_pop)
      else $error("pop from empty queue");

   // out of reset: ready for a request, no result pending
   a_reset_state: assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("bad state after reset");

endmodule
